### rtl/bprc_pkg.sv
// Shared types, constants and register codes of the pattern replace and compact block.
package bprc_pkg;

   // default sizing handed to the top level
   localparam int NEEDLE_MAX_DEF = 8;
   localparam int COUNT_BITS_DEF = 16;

   // configuration port sizing
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 64;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEEDLE_BYTES   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEEDLE_LENGTH  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REPLACE_BYTES  = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REPLACE_LENGTH = 2'd3;

   // byte value that is padded in and dropped on the way out
   localparam logic [7:0] ZERO_BYTE = 8'h00;

   // request beat
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   // response beat
   typedef struct packed {
      logic [7:0]  out_byte;
      logic        has_byte;
      logic        end_of_run;
      logic [15:0] kept_count;
   } rsp_type;

   // per-cell control from the sequencer
   typedef struct packed {
      logic load;       // take the request byte into this cell
      logic pop;        // shift the chain one place toward cell 0
      logic hit;        // full needle match on this pass
      logic in_needle;  // cell index below the active window length
      logic in_repl;    // cell index below the replacement length
   } cell_ctrl_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_TAKE,
      ST_POP,
      ST_CLOSE
   } state_type;

endpackage

### rtl/byte_pattern_replace_compact.sv
// A kept byte of a plain beat enters the response queue at the edge that accepts the beat.
// Throughput: one request beat per cycle while the response queue has room and each beat pops
// at most one window byte. A beat that leaves more than one byte to pop holds requests off in
// ST_POP; the last beat of a buffer drains the window one byte per cycle through the cell chain
// while the queue has room, then ST_CLOSE sends the final beat. The two-entry queue buffers stalls.
// Reset (synchronous): clears registers, window cells, fill, counter and queue.
module byte_pattern_replace_compact #(
   parameter int NEEDLE_MAX = bprc_pkg::NEEDLE_MAX_DEF,
   parameter int COUNT_BITS = bprc_pkg::COUNT_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  bprc_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output bprc_pkg::rsp_type                   rsp_data,
   input  logic                                csr_write,
   input  logic [bprc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bprc_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   localparam int FW = $clog2(NEEDLE_MAX + 1);
   localparam int CW = (FW > 4) ? FW : 4;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // configuration registers
   logic [63:0] needle_bytes_ff;
   logic [3:0]  needle_length_ff;
   logic [63:0] replace_bytes_ff;
   logic [3:0]  replace_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         needle_bytes_ff   <= '0;
         needle_length_ff  <= '0;
         replace_bytes_ff  <= '0;
         replace_length_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            bprc_pkg::CSR_NEEDLE_BYTES:   needle_bytes_ff   <= csr_data;
            bprc_pkg::CSR_NEEDLE_LENGTH:  needle_length_ff  <= csr_data[3:0];
            bprc_pkg::CSR_REPLACE_BYTES:  replace_bytes_ff  <= csr_data;
            bprc_pkg::CSR_REPLACE_LENGTH: replace_length_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // substitution enable and active window length
   logic          enable;
   logic [CW-1:0] win_len;

   always_comb begin
      enable = (needle_length_ff != 4'd0) &&
               (CW'(needle_length_ff) <= CW'(NEEDLE_MAX)) &&
               (replace_length_ff <= needle_length_ff);
      win_len = enable ? CW'(needle_length_ff) : CW'(1);
   end

   // sequencer state
   bprc_pkg::state_type state_ff;
   bprc_pkg::state_type state_in;
   logic [FW-1:0]       fill_ff;
   logic [FW-1:0]       fill_in;
   logic                last_ff;
   logic                last_in;
   logic                hold_valid_ff;
   logic                hold_valid_in;
   logic [7:0]          hold_byte_ff;
   logic [7:0]          hold_byte_in;
   logic [COUNT_BITS-1:0] kept_ff;
   logic [COUNT_BITS-1:0] kept_in;

   // chain wiring
   logic [NEEDLE_MAX-1:0] match_vec;
   logic [7:0]            value_lane [NEEDLE_MAX];
   logic                  out_ready;
   logic                  accept;
   logic                  active;
   logic                  cur_last;
   logic                  push_ok;
   logic [FW-1:0]         vfill;
   logic [FW-1:0]         new_fill;
   logic                  test_pop;
   logic                  drain_pop;
   logic                  pop;
   logic                  hit;
   logic                  kept;
   logic                  more;
   logic                  res_push;
   bprc_pkg::rsp_type     res_data;
   logic [31:0]           count_wide;

   always_comb begin
      count_wide = 32'(kept_ff);
   end

   // next state, chain control and result selection
   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      last_in       = last_ff;
      hold_valid_in = hold_valid_ff;
      hold_byte_in  = hold_byte_ff;
      kept_in       = kept_ff;
      res_push      = 1'b0;
      res_data      = '0;

      req_stall = !((state_ff == bprc_pkg::ST_TAKE) && out_ready);
      accept    = req_valid && !req_stall;

      case (state_ff)
         bprc_pkg::ST_TAKE: begin
            active   = accept;
            cur_last = req_data.last_byte;
         end
         bprc_pkg::ST_POP: begin
            active   = out_ready;
            cur_last = last_ff;
         end
         default: begin
            active   = 1'b0;
            cur_last = last_ff;
         end
      endcase

      // window fill after the push of this beat
      push_ok = accept && (fill_ff != FW'(NEEDLE_MAX));
      vfill   = fill_ff + FW'(push_ok);

      // test the oldest position while the window is full, drain on the last beat
      test_pop  = (CW'(vfill) >= win_len);
      drain_pop = !test_pop && cur_last && (vfill != '0);
      pop       = active && (test_pop || drain_pop);
      hit       = active && test_pop && enable && (&match_vec);
      kept      = pop && (value_lane[0] != bprc_pkg::ZERO_BYTE);
      new_fill  = vfill - FW'(pop);
      more      = (CW'(new_fill) >= win_len) || (cur_last && (new_fill != '0));

      if (active) begin
         fill_in = new_fill;
         if (state_ff == bprc_pkg::ST_TAKE) begin
            last_in = req_data.last_byte;
         end
         if (more) begin
            state_in = bprc_pkg::ST_POP;
         end else if (cur_last) begin
            state_in = bprc_pkg::ST_CLOSE;
         end else begin
            state_in = bprc_pkg::ST_TAKE;
         end
      end

      // count kept bytes, saturating
      if (kept && (kept_ff != COUNT_MAX)) begin
         kept_in = kept_ff + COUNT_BITS'(1);
      end

      // plain beats go out at once; a last run holds one byte back for the end mark
      if (kept) begin
         if (!cur_last) begin
            res_push            = 1'b1;
            res_data.out_byte   = value_lane[0];
            res_data.has_byte   = 1'b1;
         end else begin
            if (hold_valid_ff) begin
               res_push          = 1'b1;
               res_data.out_byte = hold_byte_ff;
               res_data.has_byte = 1'b1;
            end
            hold_valid_in = 1'b1;
            hold_byte_in  = value_lane[0];
         end
      end

      // close the buffer: final beat with the count, then clear for the next one
      if ((state_ff == bprc_pkg::ST_CLOSE) && out_ready) begin
         res_push            = 1'b1;
         res_data.out_byte   = hold_valid_ff ? hold_byte_ff : bprc_pkg::ZERO_BYTE;
         res_data.has_byte   = hold_valid_ff;
         res_data.end_of_run = 1'b1;
         res_data.kept_count = (count_wide > 32'h0000_FFFF) ? 16'hFFFF : count_wide[15:0];
         hold_valid_in       = 1'b0;
         kept_in             = '0;
         fill_in             = '0;
         state_in            = bprc_pkg::ST_TAKE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bprc_pkg::ST_TAKE;
         fill_ff       <= '0;
         last_ff       <= 1'b0;
         hold_valid_ff <= 1'b0;
         kept_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         last_ff       <= last_in;
         hold_valid_ff <= hold_valid_in;
         kept_ff       <= kept_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_byte_ff <= hold_byte_in;
   end

   // window as a chain of cells, cell 0 holds the oldest byte
   for (genvar j = 0; j < NEEDLE_MAX; j++) begin : g_cell
      logic [7:0]              needle_byte;
      logic [7:0]              repl_byte;
      logic [7:0]              up_value;
      bprc_pkg::cell_ctrl_type ctrl;

      // pattern bytes past the register width read as zero
      if (j < 8) begin : g_byte
         assign needle_byte = needle_bytes_ff[8*j +: 8];
         assign repl_byte   = replace_bytes_ff[8*j +: 8];
      end else begin : g_zero
         assign needle_byte = bprc_pkg::ZERO_BYTE;
         assign repl_byte   = bprc_pkg::ZERO_BYTE;
      end

      // the top cell shifts in a zero byte
      if (j == NEEDLE_MAX - 1) begin : g_top
         assign up_value = bprc_pkg::ZERO_BYTE;
      end else begin : g_mid
         assign up_value = value_lane[j+1];
      end

      always_comb begin
         ctrl.load      = push_ok && (fill_ff == FW'(j));
         ctrl.pop       = pop;
         ctrl.hit       = hit;
         ctrl.in_needle = (CW'(j) < win_len);
         ctrl.in_repl   = (CW'(j) < CW'(replace_length_ff));
      end

      bprc_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .data_byte   (req_data.data_byte),
         .up_value    (up_value),
         .needle_byte (needle_byte),
         .repl_byte   (repl_byte),
         .match       (match_vec[j]),
         .value       (value_lane[j])
      );
   end

   bprc_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .ready     (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // the window is fully drained by the time the buffer closes
   a_close_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bprc_pkg::ST_CLOSE) |-> (fill_ff == '0))
      else $error("window not drained at buffer close");

   // the kept counter restarts after the final beat
   a_count_clear: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == bprc_pkg::ST_CLOSE) && out_ready) |=> (kept_ff == '0))
      else $error("kept counter not cleared after final beat");

   // a held byte only lives inside the last run of a buffer
   a_hold_scope: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> (last_ff && (state_ff != bprc_pkg::ST_TAKE)))
      else $error("held byte outside a last run");

endmodule

### rtl/bprc_cell.sv
// One window cell: holds a byte, compares it with its needle byte and shifts toward cell 0.
module bprc_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  bprc_pkg::cell_ctrl_type ctrl,
   input  logic [7:0]              data_byte,
   input  logic [7:0]              up_value,
   input  logic [7:0]              needle_byte,
   input  logic [7:0]              repl_byte,
   output logic                    match,
   output logic [7:0]              value
);

   logic [7:0] win_ff;
   logic [7:0] win_in;
   logic [7:0] cur;

   // current content, with the incoming byte placed here on a push
   always_comb begin
      cur = ctrl.load ? data_byte : win_ff;
   end

   // compare; positions past the window always agree
   always_comb begin
      match = (cur == needle_byte) || !ctrl.in_needle;
   end

   // value after a match rewrite, handed to the lower neighbor
   always_comb begin
      if (ctrl.hit && ctrl.in_needle) begin
         value = ctrl.in_repl ? repl_byte : bprc_pkg::ZERO_BYTE;
      end else begin
         value = cur;
      end
   end

   // shift in the rewritten byte from above, or keep the current one
   always_comb begin
      win_in = ctrl.pop ? up_value : cur;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= bprc_pkg::ZERO_BYTE;
      end else begin
         win_ff <= win_in;
      end
   end

endmodule

### rtl/bprc_out_buf.sv
// Two-entry response queue that parts the sequencer from the response channel.
module bprc_out_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bprc_pkg::rsp_type push_data,
   output logic              ready,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bprc_pkg::rsp_type rsp_data
);

   bprc_pkg::rsp_type slot0_ff;
   bprc_pkg::rsp_type slot0_in;
   bprc_pkg::rsp_type slot1_ff;
   bprc_pkg::rsp_type slot1_in;
   logic [1:0]        count_ff;
   logic [1:0]        count_in;
   logic              pop;

   always_comb begin
      ready     = (count_ff != 2'd2);
      rsp_valid = (count_ff != 2'd0);
      rsp_data  = slot0_ff;
      pop       = rsp_valid && !rsp_stall;
   end

   // advance the head on a taken beat, append behind the last entry
   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff;
      if (pop) begin
         slot0_in = slot1_ff;
         count_in = count_ff - 2'd1;
      end
      if (push) begin
         if (count_in == 2'd0) begin
            slot0_in = push_data;
         end else begin
            slot1_in = push_data;
         end
         count_in = count_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule
